### src/tilt_hold_swipe_gesture_detector_assert.svh
// Assertion macros of the gesture detector checker.
`ifndef TILT_HOLD_SWIPE_GESTURE_DETECTOR_ASSERT_SVH
`define TILT_HOLD_SWIPE_GESTURE_DETECTOR_ASSERT_SVH

// Checked only outside reset.
`define THSG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define THSG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/thsg_pkg.sv
// Shared types, register indexes and defaults of the gesture detector.
package thsg_pkg;

	localparam int HOLD_DEPTH_DEF     = 5;
	localparam int SWIPE_DEPTH_DEF    = 3;
	localparam int WARMUP_SAMPLES_DEF = 10;

	localparam int SAMPLE_W = 16;
	localparam int THR_W    = 15;
	localparam int CNT_W    = 4;
	localparam int IDX_W    = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_HOLD_X_LOW   = 3'd0,
		REG_HOLD_X_HIGH  = 3'd1,
		REG_HOLD_Y_LOW   = 3'd2,
		REG_HOLD_Y_HIGH  = 3'd3,
		REG_SWIPE_THR    = 3'd4,
		REG_GRACE        = 3'd5,
		REG_REST         = 3'd6
	} reg_idx_t;

	localparam logic signed [SAMPLE_W-1:0] HOLD_X_LOW_RST  = -16'sd40;
	localparam logic signed [SAMPLE_W-1:0] HOLD_X_HIGH_RST = 16'sd40;
	localparam logic signed [SAMPLE_W-1:0] HOLD_Y_LOW_RST  = -16'sd200;
	localparam logic signed [SAMPLE_W-1:0] HOLD_Y_HIGH_RST = -16'sd120;
	localparam logic [THR_W-1:0]           SWIPE_THR_RST   = 15'd640;
	localparam logic [CNT_W-1:0]           GRACE_RST       = 4'd3;
	localparam logic [CNT_W-1:0]           REST_RST        = 4'd10;

	typedef enum logic [1:0] {
		GEST_NONE = 2'd0,
		GEST_NEXT = 2'd1,
		GEST_PREV = 2'd2
	} gesture_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x_low;
		logic signed [SAMPLE_W-1:0] x_high;
		logic signed [SAMPLE_W-1:0] y_low;
		logic signed [SAMPLE_W-1:0] y_high;
		logic [THR_W-1:0]           thr;
		logic [CNT_W-1:0]           grace;
		logic [CNT_W-1:0]           rest;
	} cfg_t;

	typedef struct packed {
		logic     armed;
		logic     holding;
		gesture_t gesture;
	} result_t;

endpackage

### src/thsg_cfg.sv
// Configuration register file of the gesture detector.
module thsg_cfg
	import thsg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [SAMPLE_W-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_low  <= HOLD_X_LOW_RST;
			cfg_q.x_high <= HOLD_X_HIGH_RST;
			cfg_q.y_low  <= HOLD_Y_LOW_RST;
			cfg_q.y_high <= HOLD_Y_HIGH_RST;
			cfg_q.thr    <= SWIPE_THR_RST;
			cfg_q.grace  <= GRACE_RST;
			cfg_q.rest   <= REST_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_HOLD_X_LOW:  cfg_q.x_low  <= cfg_data;
				REG_HOLD_X_HIGH: cfg_q.x_high <= cfg_data;
				REG_HOLD_Y_LOW:  cfg_q.y_low  <= cfg_data;
				REG_HOLD_Y_HIGH: cfg_q.y_high <= cfg_data;
				REG_SWIPE_THR:   cfg_q.thr    <= cfg_data[THR_W-1:0];
				REG_GRACE:       cfg_q.grace  <= cfg_data[CNT_W-1:0];
				REG_REST:        cfg_q.rest   <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/thsg_core.sv
// Detector state and the single-pass step logic for one sample.
module thsg_core
	import thsg_pkg::*;
#(
	parameter int HOLD_DEPTH     = HOLD_DEPTH_DEF,
	parameter int SWIPE_DEPTH    = SWIPE_DEPTH_DEF,
	parameter int WARMUP_SAMPLES = WARMUP_SAMPLES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  cfg_t                       cfg,
	input  logic                       func,
	input  logic signed [SAMPLE_W-1:0] sample_x,
	input  logic signed [SAMPLE_W-1:0] sample_y,
	output result_t                    res
);

	localparam int SEEN_W = $clog2(WARMUP_SAMPLES + 1);

	logic [HOLD_DEPTH-1:0]  still_hist_q, still_hist_d;
	logic [SWIPE_DEPTH-1:0] right_hist_q, right_hist_d;
	logic [SWIPE_DEPTH-1:0] left_hist_q, left_hist_d;
	logic [SEEN_W-1:0]      seen_q, seen_d;
	logic [CNT_W-1:0]       grace_q, grace_d;
	logic [CNT_W-1:0]       rest_q, rest_d;
	logic                   armed_q, armed_d;

	always_comb begin
		logic                   still;
		logic                   warm;
		logic                   holding;
		logic signed [THR_W+1:0] thr_s;
		logic signed [THR_W+1:0] y_s;
		logic [HOLD_DEPTH:0]    still_sh;
		logic [SWIPE_DEPTH:0]   right_sh;
		logic [SWIPE_DEPTH:0]   left_sh;
		gesture_t               gest;

		thr_s    = $signed({2'b00, cfg.thr});
		y_s      = $signed({sample_y[SAMPLE_W-1], sample_y});
		still    = (sample_x > cfg.x_low) && (sample_x < cfg.x_high) &&
		           (sample_y > cfg.y_low) && (sample_y < cfg.y_high);
		warm     = seen_q >= SEEN_W'(WARMUP_SAMPLES);
		still_sh = {still_hist_q, still};
		right_sh = {right_hist_q, (y_s >= thr_s)};
		left_sh  = {left_hist_q, (y_s <= -thr_s)};

		still_hist_d = still_hist_q;
		right_hist_d = right_hist_q;
		left_hist_d  = left_hist_q;
		seen_d       = seen_q;
		grace_d      = grace_q;
		rest_d       = rest_q;
		armed_d      = armed_q;
		holding      = 1'b0;
		gest         = GEST_NONE;

		if (!func) begin
			still_hist_d = still_sh[HOLD_DEPTH-1:0];
			if (rest_q != '0)
				rest_d = rest_q - 1'b1;
			else
				holding = &still_hist_d;
			if (holding) begin
				grace_d = cfg.grace;
				armed_d = 1'b1;
			end else if (grace_q != '0) begin
				grace_d = grace_q - 1'b1;
			end else begin
				armed_d = 1'b0;
			end
		end else begin
			right_hist_d = right_sh[SWIPE_DEPTH-1:0];
			left_hist_d  = left_sh[SWIPE_DEPTH-1:0];
			if (!warm)
				seen_d = seen_q + 1'b1;
			if (warm && armed_q) begin
				if (&right_hist_d)
					gest = GEST_NEXT;
				else if (&left_hist_d)
					gest = GEST_PREV;
			end
			if (gest != GEST_NONE) begin
				rest_d  = cfg.rest;
				armed_d = 1'b0;
				grace_d = '0;
			end
		end

		res.gesture = gest;
		res.holding = holding;
		res.armed   = armed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_hist_q <= '0;
			right_hist_q <= '0;
			left_hist_q  <= '0;
			seen_q       <= '0;
			grace_q      <= '0;
			rest_q       <= '0;
			armed_q      <= 1'b0;
		end else if (step) begin
			still_hist_q <= still_hist_d;
			right_hist_q <= right_hist_d;
			left_hist_q  <= left_hist_d;
			seen_q       <= seen_d;
			grace_q      <= grace_d;
			rest_q       <= rest_d;
			armed_q      <= armed_d;
		end
	end

endmodule

### src/tilt_hold_swipe_gesture_detector.sv
// Tilt-hold-and-swipe gesture detector, top level.
//
// Input stream (s_*): one sensor sample per request. s_tuser selects the
// stream: 0 hold sample (checked against the still window), 1 swipe sample
// (checked against the swipe threshold). s_tdata carries sample_x and
// sample_y, signed Q11.4.
// Output stream (m_*): one result per sample, in order: gesture code,
// holding flag and the acceptance flag after that sample.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while no sample is in flight.
// Flow: a request held in the input register is stepped once the result
// register is free or being read; its result is presented from that step on.
// Throughput: one sample per cycle while m_tready is high (combinational step).
// Stall: while m_tready is low the result register holds; one more sample
// waits in the input register, then s_tready drops.
// Reset: histories, counters and the armed flag clear, registers take
// their defaults, both streams come up empty.
module tilt_hold_swipe_gesture_detector
	import thsg_pkg::*;
#(
	parameter int HOLD_DEPTH     = HOLD_DEPTH_DEF,
	parameter int SWIPE_DEPTH    = SWIPE_DEPTH_DEF,
	parameter int WARMUP_SAMPLES = WARMUP_SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,   // [15:0] sample_x, [31:16] sample_y
	input  logic                s_tuser,   // [0] func
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // [1:0] gesture, [2] holding, [3] armed
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [SAMPLE_W-1:0] cfg_data
);

	cfg_t    cfg;
	result_t res;

	logic                       vld_s1;
	logic                       func_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic signed [SAMPLE_W-1:0] y_s1;
	logic                       vld_s2;
	result_t                    res_s2;
	logic                       step;

	assign step     = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			x_s1    <= s_tdata[SAMPLE_W-1:0];
			y_s1    <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
		end
	end

	thsg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	thsg_core #(
		.HOLD_DEPTH     (HOLD_DEPTH),
		.SWIPE_DEPTH    (SWIPE_DEPTH),
		.WARMUP_SAMPLES (WARMUP_SAMPLES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.cfg      (cfg),
		.func     (func_s1),
		.sample_x (x_s1),
		.sample_y (y_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (step) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res;
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {4'b0000, res_s2};

endmodule

### src/thsg_checker.sv
// Port-level checker of the gesture detector and its bind.
`include "tilt_hold_swipe_gesture_detector_assert.svh"

module thsg_checker
	import thsg_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	`THSG_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |=> !m_tvalid, "result valid during reset")
	`THSG_ASSERT(a_result_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
	`THSG_ASSERT(a_gesture_code, m_tvalid |-> m_tdata[1:0] != 2'b11, "undefined gesture code")
	`THSG_ASSERT(a_swipe_disarms, m_tvalid && m_tdata[1:0] != GEST_NONE |-> !m_tdata[3] && !m_tdata[2], "swipe left acceptance armed")
	`THSG_ASSERT(a_hold_arms, m_tvalid && m_tdata[2] |-> m_tdata[3] && m_tdata[1:0] == GEST_NONE, "hold without arming")

endmodule

bind tilt_hold_swipe_gesture_detector thsg_checker u_thsg_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the tilt-hold-and-swipe gesture detector.
module testbench;
	import thsg_pkg::*;

	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int MAX_REPORTS      = 10;
	localparam int DRAIN_CYCLES     = 4;
	localparam int PHASE_SAMPLES    = 260;

	localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam bit FUNC_HOLD  = 1'b0;
	localparam bit FUNC_SWIPE = 1'b1;

	typedef struct {
		bit                         func;
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
	} sample_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [31:0]         s_tdata   = '0;   // [15:0] sample_x, [31:16] sample_y
	logic                s_tuser   = 1'b0; // [0] func
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [7:0]          m_tdata;          // [1:0] gesture, [2] holding, [3] armed
	logic                cfg_we    = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [SAMPLE_W-1:0] cfg_data  = '0;

	// register shadow
	logic signed [SAMPLE_W-1:0] win_x_lo     = HOLD_X_LOW_RST;
	logic signed [SAMPLE_W-1:0] win_x_hi     = HOLD_X_HIGH_RST;
	logic signed [SAMPLE_W-1:0] win_y_lo     = HOLD_Y_LOW_RST;
	logic signed [SAMPLE_W-1:0] win_y_hi     = HOLD_Y_HIGH_RST;
	logic [THR_W-1:0]           swipe_thr    = SWIPE_THR_RST;
	logic [CNT_W-1:0]           grace_reload = GRACE_RST;
	logic [CNT_W-1:0]           rest_reload  = REST_RST;

	// detector state
	logic [HOLD_DEPTH_DEF-1:0]  still_hist   = '0;
	logic [SWIPE_DEPTH_DEF-1:0] right_hist   = '0;
	logic [SWIPE_DEPTH_DEF-1:0] left_hist    = '0;
	int                         swipe_cnt    = 0;
	logic [CNT_W-1:0]           grace_left   = '0;
	logic [CNT_W-1:0]           rest_left    = '0;
	bit                         accept_armed = 1'b0;

	sample_t pending_samples[$];
	result_t expected_results[$];
	sample_t drv_sample;
	result_t seen_result;
	result_t want_result;

	int queued_cnt    = 0;
	int mismatch_cnt  = 0;
	int src_idle_pct  = 13;
	int snk_idle_pct  = 62;
	int hold_off_req  = 0;
	int hold_off_ack  = 0;
	int hold_off_left = 0;
	int idle_cycles   = 0;

	tilt_hold_swipe_gesture_detector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic result_t step_detector(bit func, logic signed [SAMPLE_W-1:0] x,
			logic signed [SAMPLE_W-1:0] y);
		result_t r;
		int xi, yi, thr;
		bit still, warm;
		xi = x;
		yi = y;
		thr = swipe_thr;
		r.gesture = GEST_NONE;
		r.holding = 1'b0;
		if (func == FUNC_HOLD) begin
			still = xi > int'(win_x_lo) && xi < int'(win_x_hi) &&
				yi > int'(win_y_lo) && yi < int'(win_y_hi);
			still_hist = {still_hist[HOLD_DEPTH_DEF-2:0], still};
			if (rest_left != 0)
				rest_left = rest_left - 1'b1;
			else if (&still_hist)
				r.holding = 1'b1;
			if (r.holding) begin
				grace_left = grace_reload;
				accept_armed = 1'b1;
			end else if (grace_left != 0) begin
				grace_left = grace_left - 1'b1;
			end else begin
				accept_armed = 1'b0;
			end
		end else begin
			warm = swipe_cnt >= WARMUP_SAMPLES_DEF;
			right_hist = {right_hist[SWIPE_DEPTH_DEF-2:0], yi >= thr};
			left_hist  = {left_hist[SWIPE_DEPTH_DEF-2:0], yi <= -thr};
			if (!warm)
				swipe_cnt++;
			if (warm && accept_armed) begin
				if (&right_hist)
					r.gesture = GEST_NEXT;
				else if (&left_hist)
					r.gesture = GEST_PREV;
			end
			if (r.gesture != GEST_NONE) begin
				rest_left = rest_reload;
				accept_armed = 1'b0;
				grace_left = '0;
			end
		end
		r.armed = accept_armed;
		return r;
	endfunction

	function automatic void note_mismatch(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(step_detector(s_tuser, s_tdata[15:0],
					s_tdata[31:16]));
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					drv_sample = pending_samples.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {drv_sample.y, drv_sample.x};
					s_tuser  <= drv_sample.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_result = result_t'(m_tdata[3:0]);
				if (expected_results.size() == 0) begin
					note_mismatch($sformatf("unexpected result gesture=%0d holding=%0d armed=%0d",
						seen_result.gesture, seen_result.holding, seen_result.armed));
				end else begin
					want_result = expected_results.pop_front();
					if (seen_result.gesture != want_result.gesture ||
							seen_result.holding != want_result.holding ||
							seen_result.armed != want_result.armed)
						note_mismatch($sformatf({"mismatch: expected gesture=%0d holding=%0d ",
							"armed=%0d, got gesture=%0d holding=%0d armed=%0d"},
							want_result.gesture, want_result.holding, want_result.armed,
							seen_result.gesture, seen_result.holding, seen_result.armed));
				end
			end
			if (hold_off_req != hold_off_ack) begin
				hold_off_ack = hold_off_req;
				hold_off_left = LONG_HOLD_CYCLES;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int pick(int lo, int hi);
		if (hi <= lo)
			return lo;
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic void add_sample(bit func, int x, int y);
		sample_t s;
		s.func = func;
		s.x = x[15:0];
		s.y = y[15:0];
		pending_samples.push_back(s);
		queued_cnt++;
	endfunction

	function automatic void add_still_hold();
		add_sample(FUNC_HOLD, pick(int'(win_x_lo) + 1, int'(win_x_hi) - 1),
			pick(int'(win_y_lo) + 1, int'(win_y_hi) - 1));
	endfunction

	function automatic void add_random(bit func);
		add_sample(func, pick(-32768, 32767), pick(-32768, 32767));
	endfunction

	task automatic gen_samples(input int count);
		int goal, n, sel, i, thr;
		bit to_right;
		goal = queued_cnt + count;
		thr = swipe_thr;
		while (queued_cnt < goal) begin
			sel = $urandom_range(99);
			if (sel < 60) begin
				// still run, optional grace noise, then a swipe burst
				n = pick(3, 7) + ($urandom_range(1) ? int'(rest_reload) : 0);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(9) == 0)
						add_random(FUNC_HOLD);
					else
						add_still_hold();
				end
				n = $urandom_range(2);
				for (i = 0; i < n; i++)
					add_random(FUNC_HOLD);
				to_right = $urandom_range(1);
				n = pick(2, 4);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(99) < 15)
						add_random(FUNC_SWIPE);
					else if (to_right)
						add_sample(FUNC_SWIPE, pick(-32768, 32767), pick(thr, 32767));
					else
						add_sample(FUNC_SWIPE, pick(-32768, 32767), pick(-32768, -thr));
				end
			end else if (sel < 80) begin
				n = pick(1, 4);
				for (i = 0; i < n; i++)
					add_random(FUNC_HOLD);
			end else begin
				n = pick(1, 4);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(1))
						add_random(FUNC_SWIPE);
					else
						add_sample(FUNC_SWIPE, pick(-32768, 32767),
							($urandom_range(1) ? thr : -thr) + pick(-2, 2));
				end
			end
		end
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_HOLD_X_LOW:  win_x_lo = value;
			REG_HOLD_X_HIGH: win_x_hi = value;
			REG_HOLD_Y_LOW:  win_y_lo = value;
			REG_HOLD_Y_HIGH: win_y_hi = value;
			REG_SWIPE_THR:   swipe_thr = value[THR_W-1:0];
			REG_GRACE:       grace_reload = value[CNT_W-1:0];
			REG_REST:        rest_reload = value[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_regs(input int xl, input int xh, input int yl, input int yh,
			input int thr, input int grace, input int rest);
		write_reg(REG_HOLD_X_LOW, xl[15:0]);
		write_reg(REG_HOLD_X_HIGH, xh[15:0]);
		write_reg(REG_HOLD_Y_LOW, yl[15:0]);
		write_reg(REG_HOLD_Y_HIGH, yh[15:0]);
		write_reg(REG_SWIPE_THR, thr[15:0]);
		write_reg(REG_GRACE, grace[15:0]);
		write_reg(REG_REST, rest[15:0]);
	endtask

	task automatic load_random_window(input int thr, input int grace, input int rest);
		int xl, yl;
		xl = pick(-32768, 32000);
		yl = pick(-32768, 32000);
		load_regs(xl, pick(xl + 2, 32767 < xl + 600 ? 32767 : xl + 600),
			yl, pick(yl + 2, 32767 < yl + 600 ? 32767 : yl + 600), thr, grace, rest);
	endtask

	task automatic wait_drained();
		while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers: field extremes and window edges
		add_sample(FUNC_HOLD, -32768, -32768);
		add_sample(FUNC_HOLD, 32767, 32767);
		add_sample(FUNC_HOLD, -40, -160);
		add_sample(FUNC_HOLD, 0, -120);
		add_sample(FUNC_HOLD, -39, -199);
		add_sample(FUNC_HOLD, 39, -121);
		add_sample(FUNC_SWIPE, -32768, 32767);
		add_sample(FUNC_SWIPE, 32767, -32768);
		add_sample(FUNC_SWIPE, 0, 640);
		add_sample(FUNC_SWIPE, 0, -640);
		add_sample(FUNC_SWIPE, 0, 639);
		add_sample(FUNC_SWIPE, 0, -639);
		for (i = 0; i < 4; i++)
			add_sample(FUNC_SWIPE, 0, 700);
		wait_drained();

		// zero threshold: both directions at once, short rest, still bits kept in rest
		load_regs(-32768, 32767, -32768, 32767, 0, 1, 2);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		for (i = 0; i < 5; i++)
			add_sample(FUNC_HOLD, 0, 0);
		for (i = 0; i < 3; i++)
			add_sample(FUNC_SWIPE, 0, 0);
		for (i = 0; i < 3; i++)
			add_sample(FUNC_HOLD, 0, 0);
		wait_drained();

		// defaults again, slow receiver plus one long hold-off
		load_regs(int'(HOLD_X_LOW_RST), int'(HOLD_X_HIGH_RST), int'(HOLD_Y_LOW_RST),
			int'(HOLD_Y_HIGH_RST), int'(SWIPE_THR_RST), int'(GRACE_RST), int'(REST_RST));
		gen_samples(PHASE_SAMPLES);
		hold_off_req++;
		wait_drained();

		// long grace and rest, slow sender
		src_idle_pct = 62;
		snk_idle_pct = 13;
		load_random_window(pick(0, 2000), 15, 15);
		gen_samples(PHASE_SAMPLES);
		wait_drained();

		// no idling from here on
		src_idle_pct = 0;
		snk_idle_pct = 0;
		load_random_window(32767, 0, 0);
		gen_samples(PHASE_SAMPLES);
		wait_drained();

		load_random_window(pick(0, 32767), pick(0, 15), pick(0, 15));
		write_reg(REG_UNMAPPED, 16'h0000);
		gen_samples(PHASE_SAMPLES);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
